### src/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared shorthands for clocked concurrent assertions.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is high.
`define AIP_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds through reset.
`define AIP_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/aip_pkg.sv
// ============================================================================
// ASCII integer parser package
// Character codes, base values, phase and status codes and digit decoding.
// ============================================================================
package aip_pkg;

   localparam int VALUE_BITS     = 64;
   localparam int COUNT_OUT_BITS = 16;
   localparam int BASE_BITS      = 6;
   localparam int CHAR_BITS      = 8;
   localparam int STATUS_BITS    = 2;
   localparam int CSR_INDEX_BITS = 2;

   // Parse phases.
   localparam logic [2:0] PH_SPACE    = 3'd0;
   localparam logic [2:0] PH_START    = 3'd1;
   localparam logic [2:0] PH_DIGITS   = 3'd2;
   localparam logic [2:0] PH_DONE     = 3'd3;
   localparam logic [2:0] PH_OVF      = 3'd4;
   localparam logic [2:0] PH_OVF_DONE = 3'd5;
   localparam logic [2:0] PH_INVALID  = 3'd6;

   // Prefix progress.
   localparam logic [1:0] PFX_NONE   = 2'd0;
   localparam logic [1:0] PFX_ZERO   = 2'd1;
   localparam logic [1:0] PFX_LETTER = 2'd2;

   // Result status codes.
   localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_OVERFLOW = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_INVALID  = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BASE   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIGNED = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WIDE   = 2'd2;

   // Base values.
   localparam logic [BASE_BITS-1:0] BASE_AUTO  = 6'd0;
   localparam logic [BASE_BITS-1:0] BASE_UNARY = 6'd1;
   localparam logic [BASE_BITS-1:0] BASE_BIN   = 6'd2;
   localparam logic [BASE_BITS-1:0] BASE_OCT   = 6'd8;
   localparam logic [BASE_BITS-1:0] BASE_DEC   = 6'd10;
   localparam logic [BASE_BITS-1:0] BASE_HEX   = 6'd16;
   localparam logic [BASE_BITS-1:0] BASE_MAX   = 6'd36;
   localparam logic [BASE_BITS-1:0] NON_DIGIT  = 6'd63;

   // Character codes.
   localparam logic [CHAR_BITS-1:0] CH_TAB     = 8'h09;
   localparam logic [CHAR_BITS-1:0] CH_CR      = 8'h0D;
   localparam logic [CHAR_BITS-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_BITS-1:0] CH_PLUS    = 8'h2B;
   localparam logic [CHAR_BITS-1:0] CH_MINUS   = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CH_ZERO    = 8'h30;
   localparam logic [CHAR_BITS-1:0] CH_NINE    = 8'h39;
   localparam logic [CHAR_BITS-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CHAR_BITS-1:0] CH_UPPER_B = 8'h42;
   localparam logic [CHAR_BITS-1:0] CH_UPPER_X = 8'h58;
   localparam logic [CHAR_BITS-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [CHAR_BITS-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CHAR_BITS-1:0] CH_LOWER_B = 8'h62;
   localparam logic [CHAR_BITS-1:0] CH_LOWER_X = 8'h78;
   localparam logic [CHAR_BITS-1:0] CH_LOWER_Z = 8'h7A;

   // Per-string control state passed between the parser step and the top level.
   typedef struct packed {
      logic [2:0]           phase;
      logic                 negative;
      logic [BASE_BITS-1:0] base;
      logic [1:0]           prefix;
   } aip_ctrl_type;

   localparam aip_ctrl_type CTRL_CLEAR = '{
      phase:    PH_SPACE,
      negative: 1'b0,
      base:     BASE_AUTO,
      prefix:   PFX_NONE
   };

   // Digit value of a character, or NON_DIGIT, which is at or above every base.
   function automatic logic [BASE_BITS-1:0] digit_value(input logic [CHAR_BITS-1:0] c);
      logic [BASE_BITS-1:0] d;
      begin
         d = NON_DIGIT;
         if (c >= CH_ZERO && c <= CH_NINE) begin
            d = BASE_BITS'(c - CH_ZERO);
         end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            d = BASE_BITS'(c - CH_UPPER_A + 8'd10);
         end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            d = BASE_BITS'(c - CH_LOWER_A + 8'd10);
         end
         return d;
      end
   endfunction

   // All-ones mask of the active result width.
   function automatic logic [VALUE_BITS-1:0] value_mask(input logic wide,
                                                       input int unsigned acc_bits);
      logic [VALUE_BITS:0] ones;
      begin
         ones = '1;
         if (wide) begin
            return VALUE_BITS'(ones >> (VALUE_BITS + 1 - acc_bits));
         end
         return VALUE_BITS'(ones >> (VALUE_BITS + 1 - 32));
      end
   endfunction

endpackage

### src/aip_step.sv
// ============================================================================
// ASCII integer parser step
// Next-state logic for one character: whitespace, sign, prefix, base
// detection and the overflow-checked multiply-add of one digit.
// ============================================================================
module aip_step
   import aip_pkg::*;
#(
   parameter int COUNT_BITS = 16,
   parameter int ACC_BITS   = 64
) (
   input  logic [CHAR_BITS-1:0]  char_code,
   input  aip_ctrl_type          ctrl_ff,
   input  logic [ACC_BITS-1:0]   acc_ff,
   input  logic [COUNT_BITS-1:0] cpos_ff,
   input  logic [COUNT_BITS-1:0] epos_ff,
   input  logic [BASE_BITS-1:0]  base_setting,
   input  logic                  signed_mode,
   input  logic                  wide_mode,
   output aip_ctrl_type          ctrl_nxt,
   output logic [ACC_BITS-1:0]   acc_nxt,
   output logic [COUNT_BITS-1:0] cpos_nxt,
   output logic [COUNT_BITS-1:0] epos_nxt
);

   localparam int SUM_BITS = ACC_BITS + BASE_BITS + 1;
   localparam int CMP_BITS = VALUE_BITS + 8;

   aip_ctrl_type          cur;
   logic [COUNT_BITS-1:0] pos;
   logic [BASE_BITS-1:0]  digit;
   logic [BASE_BITS-1:0]  cand;
   logic [BASE_BITS-1:0]  take_base;
   logic                  start_num;
   logic                  take;
   logic [SUM_BITS-1:0]   sum;
   logic [VALUE_BITS-1:0] mask;
   logic [VALUE_BITS-1:0] limit;
   logic                  ovf;

   always_comb begin
      // Position counts this character and saturates at the counter's top.
      pos      = (&cpos_ff) ? cpos_ff : cpos_ff + 1'b1;
      cpos_nxt = pos;
      digit    = digit_value(char_code);

      // The base is latched on the first character of a string.
      cur = ctrl_ff;
      if (cpos_ff == '0) begin
         if (base_setting == BASE_UNARY || base_setting > BASE_MAX) begin
            cur.phase = PH_INVALID;
         end else begin
            cur.base = base_setting;
         end
      end

      ctrl_nxt  = cur;
      acc_nxt   = acc_ff;
      epos_nxt  = epos_ff;
      start_num = 1'b0;
      take      = 1'b0;
      cand      = BASE_AUTO;

      case (cur.phase)
         PH_SPACE: begin
            if (char_code inside {CH_SPACE, [CH_TAB:CH_CR]}) begin
               ctrl_nxt = cur;
            end else if (char_code == CH_MINUS || char_code == CH_PLUS) begin
               ctrl_nxt.negative = (char_code == CH_MINUS);
               ctrl_nxt.phase    = PH_START;
            end else begin
               start_num = 1'b1;
            end
         end
         PH_START: begin
            start_num = 1'b1;
         end
         PH_DIGITS: begin
            if (cur.prefix == PFX_ZERO) begin
               // A letter after a leading zero may select hex or binary.
               if (cur.base == BASE_AUTO) begin
                  if (char_code == CH_LOWER_X || char_code == CH_UPPER_X) begin
                     cand = BASE_HEX;
                  end else if (char_code == CH_LOWER_B) begin
                     cand = BASE_BIN;
                  end
               end else if (cur.base == BASE_HEX) begin
                  if (char_code == CH_LOWER_X || char_code == CH_UPPER_X) begin
                     cand = BASE_HEX;
                  end
               end else if (cur.base == BASE_BIN) begin
                  if (char_code == CH_LOWER_B || char_code == CH_UPPER_B) begin
                     cand = BASE_BIN;
                  end
               end
               if (cand != BASE_AUTO) begin
                  ctrl_nxt.base   = cand;
                  ctrl_nxt.prefix = PFX_LETTER;
               end else begin
                  if (cur.base == BASE_AUTO) begin
                     ctrl_nxt.base = BASE_OCT;
                  end
                  take = 1'b1;
               end
            end else begin
               take = 1'b1;
            end
         end
         PH_OVF: begin
            // Digits after an overflow still count as consumed.
            if (digit < cur.base) begin
               epos_nxt = pos;
            end else begin
               ctrl_nxt.phase = PH_OVF_DONE;
            end
         end
         default: begin
            ctrl_nxt = cur;
         end
      endcase

      // First character of the number proper.
      if (start_num) begin
         if (char_code == CH_ZERO &&
             (cur.base == BASE_AUTO || cur.base == BASE_HEX || cur.base == BASE_BIN)) begin
            acc_nxt         = '0;
            epos_nxt        = pos;
            ctrl_nxt.prefix = PFX_ZERO;
            ctrl_nxt.phase  = PH_DIGITS;
         end else begin
            if (cur.base == BASE_AUTO) begin
               ctrl_nxt.base = BASE_DEC;
            end
            take = 1'b1;
         end
      end

      // Multiply-add and range check against the signed or unsigned limit.
      take_base = ctrl_nxt.base;
      sum  = SUM_BITS'(acc_ff) * SUM_BITS'(take_base) + SUM_BITS'(digit);
      mask = value_mask(wide_mode, ACC_BITS);
      if (signed_mode) begin
         limit = (mask >> 1) + VALUE_BITS'(ctrl_nxt.negative);
      end else begin
         limit = mask;
      end
      ovf = CMP_BITS'(sum) > CMP_BITS'(limit);

      if (take) begin
         if (digit >= take_base) begin
            ctrl_nxt.phase = PH_DONE;
         end else begin
            ctrl_nxt.prefix = PFX_NONE;
            epos_nxt        = pos;
            if (ovf) begin
               ctrl_nxt.phase = PH_OVF;
            end else begin
               acc_nxt        = sum[ACC_BITS-1:0];
               ctrl_nxt.phase = PH_DIGITS;
            end
         end
      end
   end

endmodule

### src/ascii_integer_parser_unit.sv
// The tlast beat passes the input, finished-string and result registers, each able to stall.
// Throughput: one character beat per cycle, but a last beat waits for a free finished-string stage;
// one multiply-add of the accumulator by the base per character sets the cycle.
// Reset (synchronous): clears the parse state and all pipeline valids, and sets the
// configuration to base 10, signed, wide.
// ============================================================================
// ASCII integer parser unit
// Parses a character stream into integers, strtol style, one result per string.
// ============================================================================
module ascii_integer_parser_unit
   import aip_pkg::*;
#(
   parameter int COUNT_BITS     = 16,
   parameter int MAX_VALUE_BITS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   // Character stream
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // [7:0] char_code
   input  logic                      req_tlast,   // last_char
   // Result stream
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [79:0]               rsp_tdata,   // [63:0] value, [79:64] consumed_count
   output logic [STATUS_BITS-1:0]    rsp_tuser,   // [1:0] status
   // Configuration writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [BASE_BITS-1:0]      csr_data
);

   // Configuration registers.
   logic [BASE_BITS-1:0] base_ff;
   logic                 signed_ff;
   logic                 wide_ff;

   // Input register.
   logic                 req_valid_ff;
   logic [CHAR_BITS-1:0] req_char_ff;
   logic                 req_last_ff;

   // Per-string parse state.
   aip_ctrl_type            ctrl_ff,  ctrl_in,  ctrl_nxt;
   logic [MAX_VALUE_BITS-1:0] acc_ff, acc_in,   acc_nxt;
   logic [COUNT_BITS-1:0]   cpos_ff,  cpos_in,  cpos_nxt;
   logic [COUNT_BITS-1:0]   epos_ff,  epos_in,  epos_nxt;

   // Finished string awaiting formatting.
   logic                      fin_valid_ff, fin_valid_in;
   logic [2:0]                fin_phase_ff;
   logic                      fin_neg_ff;
   logic [MAX_VALUE_BITS-1:0] fin_acc_ff;
   logic [COUNT_BITS-1:0]     fin_epos_ff;
   logic                      fin_signed_ff;
   logic                      fin_wide_ff;

   // Result register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0]     rsp_value_ff;
   logic [COUNT_OUT_BITS-1:0] rsp_count_ff;
   logic [STATUS_BITS-1:0]    rsp_status_ff;

   // Pipeline flow.
   logic out_free;
   logic fin_free;
   logic fin_go;
   logic step_go;

   // Formatting.
   logic [VALUE_BITS-1:0]     fmt_mask;
   logic [VALUE_BITS-1:0]     fmt_mag;
   logic [VALUE_BITS-1:0]     fmt_neg;
   logic [VALUE_BITS-1:0]     fmt_value;
   logic [COUNT_OUT_BITS-1:0] fmt_count;
   logic [STATUS_BITS-1:0]    fmt_status;

   // Handshakes: a stage loads when it is empty or its beat moves on.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fin_free   = !fin_valid_ff || out_free;
   assign fin_go     = fin_valid_ff && out_free;
   assign step_go    = req_valid_ff && (!req_last_ff || fin_free);
   assign req_tready = !req_valid_ff || step_go;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_count_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_status_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= BASE_DEC;
         signed_ff <= 1'b1;
         wide_ff   <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_BASE:   base_ff   <= csr_data;
            CSR_SIGNED: signed_ff <= csr_data[0];
            CSR_WIDE:   wide_ff   <= csr_data[0];
            default:    base_ff   <= base_ff;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_char_ff <= req_tdata;
         req_last_ff <= req_tlast;
      end
   end

   // One character of parsing.
   aip_step #(
      .COUNT_BITS (COUNT_BITS),
      .ACC_BITS   (MAX_VALUE_BITS)
   ) u_step (
      .char_code    (req_char_ff),
      .ctrl_ff      (ctrl_ff),
      .acc_ff       (acc_ff),
      .cpos_ff      (cpos_ff),
      .epos_ff      (epos_ff),
      .base_setting (base_ff),
      .signed_mode  (signed_ff),
      .wide_mode    (wide_ff),
      .ctrl_nxt     (ctrl_nxt),
      .acc_nxt      (acc_nxt),
      .cpos_nxt     (cpos_nxt),
      .epos_nxt     (epos_nxt)
   );

   // Parse state advances per character and clears after the last one.
   always_comb begin
      ctrl_in = ctrl_ff;
      acc_in  = acc_ff;
      cpos_in = cpos_ff;
      epos_in = epos_ff;
      if (step_go) begin
         if (req_last_ff) begin
            ctrl_in = CTRL_CLEAR;
            acc_in  = '0;
            cpos_in = '0;
            epos_in = '0;
         end else begin
            ctrl_in = ctrl_nxt;
            acc_in  = acc_nxt;
            cpos_in = cpos_nxt;
            epos_in = epos_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= CTRL_CLEAR;
         acc_ff  <= '0;
         cpos_ff <= '0;
         epos_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_in;
         acc_ff  <= acc_in;
         cpos_ff <= cpos_in;
         epos_ff <= epos_in;
      end
   end

   // Capture the finished string.
   assign fin_valid_in = (step_go && req_last_ff) ? 1'b1 : (fin_go ? 1'b0 : fin_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= fin_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_go && req_last_ff) begin
         fin_phase_ff  <= ctrl_nxt.phase;
         fin_neg_ff    <= ctrl_nxt.negative;
         fin_acc_ff    <= acc_nxt;
         fin_epos_ff   <= epos_nxt;
         fin_signed_ff <= signed_ff;
         fin_wide_ff   <= wide_ff;
      end
   end

   // Saturation, sign and width of the final value.
   always_comb begin
      fmt_mask   = value_mask(fin_wide_ff, MAX_VALUE_BITS);
      fmt_mag    = VALUE_BITS'(fin_acc_ff);
      fmt_neg    = '0 - fmt_mag;
      fmt_count  = COUNT_OUT_BITS'(fin_epos_ff);
      fmt_status = ST_OK;
      fmt_value  = fmt_mag;
      case (fin_phase_ff)
         PH_INVALID: begin
            fmt_value  = '0;
            fmt_count  = '0;
            fmt_status = ST_INVALID;
         end
         PH_OVF, PH_OVF_DONE: begin
            fmt_status = ST_OVERFLOW;
            if (fin_signed_ff) begin
               fmt_value = fin_neg_ff ? ~(fmt_mask >> 1) : (fmt_mask >> 1);
            end else begin
               fmt_value = fmt_mask;
            end
         end
         default: begin
            if (fin_neg_ff) begin
               fmt_value = fin_signed_ff ? fmt_neg : (fmt_neg & fmt_mask);
            end
         end
      endcase
   end

   // Result register.
   assign rsp_valid_in = fin_go ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_go) begin
         rsp_value_ff  <= fmt_value;
         rsp_count_ff  <= fmt_count;
         rsp_status_ff <= fmt_status;
      end
   end

endmodule

### src/aip_checker.sv
// ============================================================================
// ASCII integer parser checker
// Port-level checks on the result stream, bound to the top level.
// ============================================================================
`include "assert_macros.svh"

module aip_checker
   import aip_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [79:0]            rsp_tdata,
   input logic [STATUS_BITS-1:0] rsp_tuser
);

   // A stalled result beat stays offered.
   `AIP_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "result beat dropped while stalled")

   // The status code is always one of the defined ones.
   `AIP_ASSERT(a_status_code, clock, reset, rsp_tvalid |-> rsp_tuser <= ST_INVALID, "undefined status code")

   // An invalid base gives a zero value and a zero count.
   `AIP_ASSERT(a_invalid_zero, clock, reset, rsp_tvalid && rsp_tuser == ST_INVALID |-> rsp_tdata == 80'd0, "invalid base with nonzero result")

   // Nothing is offered right after reset.
   `AIP_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid, "result offered after reset")

   // A stalled result beat keeps its contents.
   `AIP_ASSERT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser), "result beat changed while stalled")

endmodule

bind ascii_integer_parser_unit aip_checker u_aip_checker (.*);
